// File: rtl/sync_word_length_deframer_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef SYNC_WORD_LENGTH_DEFRAMER_MACROS_SVH
`define SYNC_WORD_LENGTH_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication within the same cycle.
`define SWLD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");

// Check an implication in the next cycle.
`define SWLD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");

`else

`define SWLD_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SWLD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: rtl/swld_pkg.sv
// Package with constants of the sync word length deframer.
package swld_pkg;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int PATTERN_W  = 16;

   localparam logic [PATTERN_W-1:0] START_PATTERN_RST = 16'h7878;

   localparam logic REG_START_PATTERN = 1'b0;

endpackage

// File: rtl/sync_word_length_deframer.sv
// Sync word length deframer: hunts a sync word, reads a byte count, emits payload bits.
//
// Input channel (req_): one received line bit per word, accepted when req_valid is high
// and req_stall is low. Result channel (rsp_): at most one result word per input word:
// a payload bit with last_bit set on the final bit of a frame, or a single empty_frame
// word when the byte count is zero. Hunt bits and all but the last length bit give none.
// Configuration: the APB-style port holds start_pattern at byte address 0; its low
// SYNC_WIDTH bits (zero above bit 15) are matched against the last bits received.
// Output: a result appears on rsp_ in the cycle after its input word is accepted.
// Throughput: one input word per cycle unless req_stall is high; state and result are
// formed by one pass of shift-and-count logic into the state and output registers.
// Stall: the output register holds a result while rsp_stall is high; req_stall rises
// only while that register is full and stalled, and drops as it drains.
// Reset: synchronous, active high; the block returns to hunt with all shift registers
// and counters clear, the output register empty, and start_pattern at 0x7878.
// Back-to-back frames: after the last bit of a frame the next word is again hunted.
`include "sync_word_length_deframer_macros.svh"

module sync_word_length_deframer #(
   parameter int SYNC_WIDTH   = 16,
   parameter int LENGTH_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_rx_bit,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_payload_bit,
   output logic                             rsp_last_bit,
   output logic                             rsp_empty_frame,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [swld_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [swld_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [swld_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import swld_pkg::*;

   localparam int CNT_W = $clog2(LENGTH_WIDTH + 1);
   localparam int REM_W = LENGTH_WIDTH + 3;

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_LENGTH = 2'd1,
      PH_DATA   = 2'd2
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [SYNC_WIDTH-1:0]   sync_ff, sync_in;
   logic [LENGTH_WIDTH-1:0] len_ff, len_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [PATTERN_W-1:0]    pattern_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_payload_ff, rsp_last_ff, rsp_empty_ff;

   logic                    accept;
   logic                    csr_write;
   logic                    res_valid, res_payload, res_last, res_empty;
   logic [31:0]             pattern_ext;
   logic [SYNC_WIDTH-1:0]   pattern_cmp;
   logic [SYNC_WIDTH-1:0]   sync_shift;
   logic [LENGTH_WIDTH-1:0] len_shift;
   logic [CNT_W-1:0]        cnt_next;
   logic [REM_W-1:0]        rem_load;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   assign pattern_ext = {{(32 - PATTERN_W){1'b0}}, pattern_ff};
   assign pattern_cmp = pattern_ext[SYNC_WIDTH-1:0];
   assign sync_shift  = {sync_ff[SYNC_WIDTH-2:0], req_rx_bit};
   assign len_shift   = {len_ff[LENGTH_WIDTH-2:0], req_rx_bit};
   assign cnt_next    = cnt_ff + CNT_W'(1);
   assign rem_load    = {len_shift, 3'b000};

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_START_PATTERN) begin
         prdata = {{(CSR_DATA_W - PATTERN_W){1'b0}}, pattern_ff};
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      sync_in     = sync_ff;
      len_in      = len_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      res_valid   = 1'b0;
      res_payload = 1'b0;
      res_last    = 1'b0;
      res_empty   = 1'b0;
      unique case (phase_ff)
         PH_LENGTH: begin
            len_in = len_shift;
            cnt_in = cnt_next;
            if (cnt_next == CNT_W'(LENGTH_WIDTH)) begin
               if (len_shift == '0) begin
                  res_valid = 1'b1;
                  res_last  = 1'b1;
                  res_empty = 1'b1;
                  phase_in  = PH_HUNT;
                  sync_in   = '0;
                  len_in    = '0;
                  cnt_in    = '0;
                  rem_in    = '0;
               end else begin
                  rem_in   = rem_load;
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            rem_in      = rem_ff - REM_W'(1);
            res_valid   = 1'b1;
            res_payload = req_rx_bit;
            if (rem_ff == REM_W'(1)) begin
               res_last = 1'b1;
               phase_in = PH_HUNT;
               sync_in  = '0;
               len_in   = '0;
               cnt_in   = '0;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            sync_in  = sync_shift;
            if (sync_shift == pattern_cmp) begin
               phase_in = PH_LENGTH;
               len_in   = '0;
               cnt_in   = '0;
               rem_in   = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         sync_ff      <= '0;
         len_ff       <= '0;
         cnt_ff       <= '0;
         rem_ff       <= '0;
         pattern_ff   <= START_PATTERN_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write && paddr[2] == REG_START_PATTERN) begin
            pattern_ff <= pwdata[PATTERN_W-1:0];
         end
         if (accept) begin
            phase_ff <= phase_in;
            sync_ff  <= sync_in;
            len_ff   <= len_in;
            cnt_ff   <= cnt_in;
            rem_ff   <= rem_in;
         end
         if (accept && res_valid) begin
            rsp_valid_ff   <= 1'b1;
            rsp_payload_ff <= res_payload;
            rsp_last_ff    <= res_last;
            rsp_empty_ff   <= res_empty;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload_bit = rsp_payload_ff;
   assign rsp_last_bit    = rsp_last_ff;
   assign rsp_empty_frame = rsp_empty_ff;

   `SWLD_ASSERT_SAME(a_empty_is_last, clock, reset,
      rsp_valid && rsp_empty_frame, rsp_last_bit && !rsp_payload_bit)
   `SWLD_ASSERT_SAME(a_data_has_bits, clock, reset,
      phase_ff == PH_DATA, rem_ff != '0)
   `SWLD_ASSERT_SAME(a_hunt_counters_clear, clock, reset,
      phase_ff == PH_HUNT, cnt_ff == '0 && rem_ff == '0 && len_ff == '0)
   `SWLD_ASSERT_NEXT(a_last_returns_hunt, clock, reset,
      accept && res_valid && res_last, phase_ff == PH_HUNT && sync_ff == '0)

endmodule
